// ===== design/mnp_pkg.sv =====
`default_nettype none

package mnp_pkg;

	localparam int PITCH_COUNT = 128;
	localparam int TIME_BITS = 32;
	localparam int PITCH_W = (PITCH_COUNT > 1) ? $clog2(PITCH_COUNT) : 1;

	localparam logic [1:0] EV_KEY_ON = 2'd0;
	localparam logic [1:0] EV_KEY_OFF = 2'd1;

	localparam logic [1:0] RES_NOTE = 2'd0;
	localparam logic [1:0] RES_PASS = 2'd1;
	localparam logic [1:0] RES_UNMATCHED = 2'd2;

	typedef logic [PITCH_W-1:0] slot_idx_t;
	typedef logic [TIME_BITS-1:0] tick_t;

	typedef struct packed {
		logic [6:0] vel;
		logic [3:0] chan;
		tick_t      tick;
	} slot_entry_t;

	typedef struct packed {
		logic        en;
		slot_idx_t   idx;
		slot_entry_t data;
	} slot_wr_t;

	typedef struct packed {
		logic      set;
		logic      clr;
		slot_idx_t idx;
	} held_upd_t;

	function automatic tick_t to_tick(logic [31:0] v);
		return tick_t'(64'(v));
	endfunction

	function automatic logic [31:0] to_out(tick_t v);
		return 32'(64'(v));
	endfunction

endpackage

`default_nettype wire

// ===== design/mnp_slot_ram.sv =====
`default_nettype none

module mnp_slot_ram (
	input  wire                       clk,
	input  wire mnp_pkg::slot_wr_t    wr,
	input  wire                       rd_en,
	input  wire mnp_pkg::slot_idx_t   rd_idx,
	output mnp_pkg::slot_entry_t      rd_data
);

	mnp_pkg::slot_entry_t mem [mnp_pkg::PITCH_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ===== design/mnp_held_table.sv =====
`default_nettype none

module mnp_held_table (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire mnp_pkg::held_upd_t  upd,
	input  wire mnp_pkg::slot_idx_t  rd_idx,
	output logic                     rd_held
);

	logic [mnp_pkg::PITCH_COUNT-1:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (upd.set) begin
			held_q[upd.idx] <= 1'b1;
		end else if (upd.clr) begin
			held_q[upd.idx] <= 1'b0;
		end
	end

	assign rd_held = held_q[rd_idx];

endmodule

`default_nettype wire

// ===== design/midi_note_on_off_pairing.sv =====
// an accepted event beat is held in the stage-one registers, and its result is then loaded into the output register
// throughput: one event per cycle unless a result is stalled at the output, set by the registered read of the slot ram
// a key on just ahead of an event of the same pitch is forwarded around the ram
// reset: asynchronous, active low; held flags clear at once, no clearing pass
// slot ram contents are not reset and are used only while the held flag is set
`default_nettype none

module midi_note_on_off_pairing (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  event_kind,
	input  wire  [6:0]  key_pitch,
	input  wire  [6:0]  key_velocity,
	input  wire  [3:0]  midi_channel,
	input  wire  [31:0] event_time,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  result_kind,
	output logic [6:0]  out_pitch,
	output logic [6:0]  out_velocity,
	output logic [3:0]  out_channel,
	output logic [31:0] start_time,
	output logic [31:0] note_length
);

	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [6:0]           pitch_s1;
	logic [6:0]           vel_s1;
	logic [3:0]           chan_s1;
	logic [31:0]          time_s1;
	logic                 fwd_hit_s1;
	mnp_pkg::slot_entry_t fwd_data_s1;

	mnp_pkg::slot_entry_t rd_data;
	mnp_pkg::slot_entry_t entry_s1;
	mnp_pkg::slot_wr_t    wr;
	mnp_pkg::held_upd_t   upd;
	mnp_pkg::slot_idx_t   idx_s1;
	mnp_pkg::slot_idx_t   idx_in;
	mnp_pkg::tick_t       tick_s1;
	mnp_pkg::tick_t       len_s1;
	logic                 held_rd;
	logic                 held_s1;
	logic                 in_table_s1;
	logic                 is_on_s1;
	logic                 is_off_s1;
	logic                 out_free;
	logic                 fire_s1;
	logic                 accept;

	assign idx_in = key_pitch[mnp_pkg::PITCH_W-1:0];
	assign idx_s1 = pitch_s1[mnp_pkg::PITCH_W-1:0];
	assign in_table_s1 = {1'b0, pitch_s1} < 8'(mnp_pkg::PITCH_COUNT);
	assign is_on_s1 = kind_s1 == mnp_pkg::EV_KEY_ON;
	assign is_off_s1 = kind_s1 == mnp_pkg::EV_KEY_OFF;
	assign held_s1 = held_rd && in_table_s1;
	assign entry_s1 = fwd_hit_s1 ? fwd_data_s1 : rd_data;
	assign tick_s1 = mnp_pkg::to_tick(time_s1);
	assign len_s1 = tick_s1 - entry_s1.tick;

	assign out_free = !out_valid || out_ready;
	assign fire_s1 = valid_s1 && (is_on_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;
	assign accept = in_valid && in_ready;

	always_comb begin
		wr.en = fire_s1 && is_on_s1 && in_table_s1;
		wr.idx = idx_s1;
		wr.data.vel = vel_s1;
		wr.data.chan = chan_s1;
		wr.data.tick = tick_s1;
		upd.set = wr.en;
		upd.clr = fire_s1 && is_off_s1 && held_s1;
		upd.idx = idx_s1;
	end

	mnp_slot_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept),
		.rd_idx  (idx_in),
		.rd_data (rd_data)
	);

	mnp_held_table u_held (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.rd_idx  (idx_s1),
		.rd_held (held_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_hit_s1 <= wr.en && (wr.idx == idx_in);
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= event_kind;
			pitch_s1 <= key_pitch;
			vel_s1 <= key_velocity;
			chan_s1 <= midi_channel;
			time_s1 <= event_time;
			fwd_data_s1 <= wr.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire_s1 && !is_on_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && !is_on_s1) begin
			out_pitch <= pitch_s1;
			if (is_off_s1 && held_s1) begin
				result_kind <= mnp_pkg::RES_NOTE;
				out_velocity <= entry_s1.vel;
				out_channel <= entry_s1.chan;
				start_time <= mnp_pkg::to_out(entry_s1.tick);
				note_length <= mnp_pkg::to_out(len_s1);
			end else begin
				result_kind <= is_off_s1 ? mnp_pkg::RES_UNMATCHED : mnp_pkg::RES_PASS;
				out_velocity <= vel_s1;
				out_channel <= chan_s1;
				start_time <= mnp_pkg::to_out(tick_s1);
				note_length <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mnp_checker.sv =====
`default_nettype none

module mnp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [1:0]  result_kind,
	input wire [6:0]  out_pitch,
	input wire [6:0]  out_velocity,
	input wire [3:0]  out_channel,
	input wire [31:0] start_time,
	input wire [31:0] note_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(out_pitch)
			&& $stable(out_velocity) && $stable(out_channel)
			&& $stable(start_time) && $stable(note_length))
		else $error("stalled result beat changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind == mnp_pkg::RES_NOTE || result_kind == mnp_pkg::RES_PASS
			|| result_kind == mnp_pkg::RES_UNMATCHED)
		else $error("illegal result kind");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != mnp_pkg::RES_NOTE |-> note_length == 32'd0)
		else $error("non-note result with nonzero length");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output side empty");

endmodule

bind midi_note_on_off_pairing mnp_checker u_mnp_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] EV_OTHER = 2'd2;
	localparam logic [1:0] EV_SPARE = 2'd3;
	localparam int RANDOM_EVENTS = 1250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  pitch;
		logic [6:0]  vel;
		logic [3:0]  chan;
		logic [31:0] start;
		logic [31:0] len;
	} note_rec_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  pitch;
		logic [6:0]  vel;
		logic [3:0]  chan;
		logic [31:0] tick;
		bit          typed;
		bit          emits;
		note_rec_t   want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  event_kind = '0;
	logic [6:0]  key_pitch = '0;
	logic [6:0]  key_velocity = '0;
	logic [3:0]  midi_channel = '0;
	logic [31:0] event_time = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [6:0]  out_pitch;
	logic [6:0]  out_velocity;
	logic [3:0]  out_channel;
	logic [31:0] start_time;
	logic [31:0] note_length;

	// predictor copy of the note store
	bit              key_down [mnp_pkg::PITCH_COUNT];
	logic [6:0]      down_vel [mnp_pkg::PITCH_COUNT];
	logic [3:0]      down_chan [mnp_pkg::PITCH_COUNT];
	mnp_pkg::tick_t  down_tick [mnp_pkg::PITCH_COUNT];

	note_rec_t   due_notes [$];
	stim_row_t   directed_rows [$];
	note_rec_t   got_want;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [31:0] now_tick = '0;

	midi_note_on_off_pairing i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.event_kind   (event_kind),
		.key_pitch    (key_pitch),
		.key_velocity (key_velocity),
		.midi_channel (midi_channel),
		.event_time   (event_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.out_pitch    (out_pitch),
		.out_velocity (out_velocity),
		.out_channel  (out_channel),
		.start_time   (start_time),
		.note_length  (note_length)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d notes still due", cycle_count,
				due_notes.size());
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0d: mismatch %s: got %0h want %0h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// result beat check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_notes.size() == 0) begin
				flag_mismatch("unexpected result, kind", 64'(result_kind), 64'(0));
			end else begin
				got_want = due_notes.pop_front();
				if (result_kind !== got_want.kind)
					flag_mismatch("result_kind", 64'(result_kind), 64'(got_want.kind));
				if (out_pitch !== got_want.pitch)
					flag_mismatch("out_pitch", 64'(out_pitch), 64'(got_want.pitch));
				if (out_velocity !== got_want.vel)
					flag_mismatch("out_velocity", 64'(out_velocity), 64'(got_want.vel));
				if (out_channel !== got_want.chan)
					flag_mismatch("out_channel", 64'(out_channel), 64'(got_want.chan));
				if (start_time !== got_want.start)
					flag_mismatch("start_time", 64'(start_time), 64'(got_want.start));
				if (note_length !== got_want.len)
					flag_mismatch("note_length", 64'(note_length), 64'(got_want.len));
			end
		end
	end

	function automatic bit pair_event(input logic [1:0] kind, input logic [6:0] pitch,
		input logic [6:0] vel, input logic [3:0] chan, input logic [31:0] tick,
		output note_rec_t res);
		mnp_pkg::tick_t t;
		bit             in_table;
		t = mnp_pkg::tick_t'(tick);
		in_table = (int'(pitch) < mnp_pkg::PITCH_COUNT);
		res = '0;
		if (kind == mnp_pkg::EV_KEY_ON) begin
			if (in_table) begin
				key_down[pitch] = 1'b1;
				down_vel[pitch] = vel;
				down_chan[pitch] = chan;
				down_tick[pitch] = t;
			end
			return 1'b0;
		end
		if (kind == mnp_pkg::EV_KEY_OFF && in_table && key_down[pitch]) begin
			res.kind = mnp_pkg::RES_NOTE;
			res.pitch = pitch;
			res.vel = down_vel[pitch];
			res.chan = down_chan[pitch];
			res.start = 32'(down_tick[pitch]);
			res.len = 32'(mnp_pkg::tick_t'(t - down_tick[pitch]));
			key_down[pitch] = 1'b0;
		end else begin
			res.kind = (kind == mnp_pkg::EV_KEY_OFF) ? mnp_pkg::RES_UNMATCHED
				: mnp_pkg::RES_PASS;
			res.pitch = pitch;
			res.vel = vel;
			res.chan = chan;
			res.start = 32'(t);
			res.len = '0;
		end
		return 1'b1;
	endfunction

	task automatic send_event(input logic [1:0] kind, input logic [6:0] pitch,
		input logic [6:0] vel, input logic [3:0] chan, input logic [31:0] tick,
		input bit typed, input bit emits, input note_rec_t want);
		note_rec_t predicted;
		bit        has_result;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		event_kind <= kind;
		key_pitch <= pitch;
		key_velocity <= vel;
		midi_channel <= chan;
		event_time <= tick;
		do @(posedge clk); while (!in_ready);
		has_result = pair_event(kind, pitch, vel, chan, tick, predicted);
		if (typed) begin
			if (emits)
				due_notes = {due_notes, want};
		end else if (has_result) begin
			due_notes = {due_notes, predicted};
		end
	endtask

	task automatic add_row(input logic [1:0] kind, input logic [6:0] pitch,
		input logic [6:0] vel, input logic [3:0] chan, input logic [31:0] tick,
		input bit typed, input bit emits, input logic [1:0] rk, input logic [6:0] rp,
		input logic [6:0] rv, input logic [3:0] rc, input logic [31:0] rs,
		input logic [31:0] rl);
		stim_row_t row;
		row.kind = kind;
		row.pitch = pitch;
		row.vel = vel;
		row.chan = chan;
		row.tick = tick;
		row.typed = typed;
		row.emits = emits;
		row.want = '{kind: rk, pitch: rp, vel: rv, chan: rc, start: rs, len: rl};
		directed_rows = {directed_rows, row};
	endtask

	// sender stops until every due note has come back
	task automatic drain_notes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_notes.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		int         r;
		int         p0;
		int         idx;
		bit         found;
		logic [1:0] kind;
		logic [6:0] pitch;
		note_rec_t  none;
		none = '0;
		r = $urandom_range(99);
		if (r < 10)
			now_tick = $urandom;
		else if (r > 5 && r < 12)
			now_tick = now_tick;
		else
			now_tick = now_tick + $urandom_range(300);
		r = $urandom_range(99);
		if (r < 25)
			pitch = 7'($urandom_range(3));
		else if (r < 32)
			pitch = 7'($urandom_range(127, 124));
		else
			pitch = 7'($urandom_range(127));
		r = $urandom_range(99);
		if (r < 45)
			kind = mnp_pkg::EV_KEY_ON;
		else if (r < 85)
			kind = mnp_pkg::EV_KEY_OFF;
		else if (r < 95)
			kind = EV_OTHER;
		else
			kind = EV_SPARE;
		// key off mostly closes a held note
		if (kind == mnp_pkg::EV_KEY_OFF && $urandom_range(99) < 75) begin
			found = 1'b0;
			p0 = $urandom_range(mnp_pkg::PITCH_COUNT - 1);
			for (int i = 0; i < mnp_pkg::PITCH_COUNT; i++) begin
				idx = (p0 + i) % mnp_pkg::PITCH_COUNT;
				if (!found && key_down[idx]) begin
					found = 1'b1;
					pitch = 7'(idx);
				end
			end
		end
		send_event(kind, pitch, 7'($urandom_range(127)), 4'($urandom_range(15)), now_tick,
			1'b0, 1'b0, none);
	endtask

	initial begin
		stim_row_t row;
		// after reset nothing is held
		add_row(mnp_pkg::EV_KEY_OFF, 7'd0, 7'd5, 4'd3, 32'h0000_0000,
			1, 1, mnp_pkg::RES_UNMATCHED, 7'd0, 7'd5, 4'd3, 32'h0000_0000, 32'd0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd127, 7'd127, 4'd15, 32'hffff_ffff,
			1, 1, mnp_pkg::RES_UNMATCHED, 7'd127, 7'd127, 4'd15, 32'hffff_ffff, 32'd0);
		add_row(EV_OTHER, 7'd127, 7'd127, 4'd15, 32'hffff_ffff,
			1, 1, mnp_pkg::RES_PASS, 7'd127, 7'd127, 4'd15, 32'hffff_ffff, 32'd0);
		// unknown kind passes through
		add_row(EV_SPARE, 7'd0, 7'd0, 4'd0, 32'h0000_0000,
			1, 1, mnp_pkg::RES_PASS, 7'd0, 7'd0, 4'd0, 32'h0000_0000, 32'd0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd0, 7'd127, 4'd15, 32'hffff_fff0,
			1, 0, mnp_pkg::RES_NOTE, 7'd0, 7'd0, 4'd0, 32'd0, 32'd0);
		// duration wraps across zero
		add_row(mnp_pkg::EV_KEY_OFF, 7'd0, 7'd1, 4'd2, 32'h0000_0010,
			1, 1, mnp_pkg::RES_NOTE, 7'd0, 7'd127, 4'd15, 32'hffff_fff0, 32'h0000_0020);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd0, 7'd1, 4'd2, 32'h0000_0020,
			1, 1, mnp_pkg::RES_UNMATCHED, 7'd0, 7'd1, 4'd2, 32'h0000_0020, 32'd0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd127, 7'd0, 4'd0, 32'd100,
			1, 0, mnp_pkg::RES_NOTE, 7'd0, 7'd0, 4'd0, 32'd0, 32'd0);
		// overwrite of a held slot
		add_row(mnp_pkg::EV_KEY_ON, 7'd127, 7'd64, 4'd9, 32'd200,
			1, 0, mnp_pkg::RES_NOTE, 7'd0, 7'd0, 4'd0, 32'd0, 32'd0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd127, 7'd3, 4'd3, 32'd150,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd60, 7'd33, 4'd1, 32'd1000,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(EV_OTHER, 7'd60, 7'd7, 4'd7, 32'd1001, 0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd60, 7'd0, 4'd0, 32'd1000,
			0, 0, '0, '0, '0, '0, '0, '0);
		// back to back on and off of one pitch
		add_row(mnp_pkg::EV_KEY_ON, 7'd61, 7'd21, 4'd4, 32'd2000,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd61, 7'd0, 4'd0, 32'd2005,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd62, 7'd10, 4'd5, 32'd3000,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd62, 7'd90, 4'd6, 32'd3100,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd62, 7'd0, 4'd0, 32'd3150,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd63, 7'd42, 4'd10, 32'd4000,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_ON, 7'd64, 7'd85, 4'd5, 32'd4001,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd63, 7'd1, 4'd1, 32'd4500,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd64, 7'd1, 4'd1, 32'd4600,
			0, 0, '0, '0, '0, '0, '0, '0);
		add_row(mnp_pkg::EV_KEY_OFF, 7'd62, 7'd99, 4'd12, 32'd5000,
			0, 0, '0, '0, '0, '0, '0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_event(row.kind, row.pitch, row.vel, row.chan, row.tick,
				row.typed, row.emits, row.want);
		end

		now_tick = $urandom;
		for (int ph = 0; ph < 3; ph++) begin
			drain_notes();
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 46 : 0;
			recv_stall_pct = (ph == 0) ? 46 : (ph == 1) ? 16 : 0;
			repeat (RANDOM_EVENTS / 3)
				send_random();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_notes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
